// ===== hdl/rs485_half_duplex_fifo_controller_defines.svh =====
// ----------------------------------------------------------------------------
// RS-485 half-duplex controller assertion macros
// Shared macros for the concurrent checks of the controller. They expect
// signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef RS485_HALF_DUPLEX_FIFO_CONTROLLER_DEFINES_SVH
`define RS485_HALF_DUPLEX_FIFO_CONTROLLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RS485HD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RS485HD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rs485hd_pkg.sv =====
// ----------------------------------------------------------------------------
// RS-485 half-duplex controller package
// Widths, command codes, internal operation codes and the structs that pass
// between the front and back parts of the controller.
// ----------------------------------------------------------------------------
package rs485hd_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;

  // Default FIFO depths.
  localparam int RX_DEPTH_DEFAULT = 32;
  localparam int TX_DEPTH_DEFAULT = 16;

  // Depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes as they arrive on the input channel.
  localparam logic [CMD_W-1:0] CMD_QUEUE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DONE   = 2'd3;

  // Operations after classification by the front part.
  typedef enum logic [3:0] {
    OP_QUEUE  = 4'b0001,
    OP_TAKE   = 4'b0010,
    OP_ARRIVE = 4'b0100,
    OP_DONE   = 4'b1000
  } op_t;

  // One queued operation.
  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

  // Status of the back part, watched by the top level.
  typedef struct packed {
    logic read_wait;
    logic transmitting;
    logic send_empty;
  } back_status_t;

endpackage

// ===== hdl/rs485hd_in_if.sv =====
// ----------------------------------------------------------------------------
// RS-485 controller command channel
// Valid/ready channel carrying one command word and its data byte.
// ----------------------------------------------------------------------------
interface rs485hd_in_if import rs485hd_pkg::*;;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);

endinterface

// ===== hdl/rs485hd_out_if.sv =====
// ----------------------------------------------------------------------------
// RS-485 controller result channel
// Valid/ready channel carrying one result word per command.
// ----------------------------------------------------------------------------
interface rs485hd_out_if import rs485hd_pkg::*;;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [BYTE_W-1:0] read_byte;
  logic              launch_valid;
  logic [BYTE_W-1:0] launch_byte;
  logic              driver_on;

  modport source (
    output valid, output ok, output read_byte, output launch_valid,
    output launch_byte, output driver_on, input ready
  );
  modport sink (
    input valid, input ok, input read_byte, input launch_valid,
    input launch_byte, input driver_on, output ready
  );

endinterface

// ===== hdl/rs485_half_duplex_fifo_controller.sv =====
// A result word passes the front queue and the output register after its command
// word is accepted, and the S_READ state too when it pops a FIFO (registered RAM
// read). Throughput: 1 word per cycle while the result channel is ready; a word
// that pops a FIFO holds the execution stage in S_READ for the RAM read.
// Reset: synchronous, active low; clears pointers, counts and line direction
// (receive). FIFO storage is not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// RS-485 half-duplex FIFO controller
// Top level: a front part accepts and classifies command words, a back part
// runs them against the send and receive FIFOs and the driver direction.
// ----------------------------------------------------------------------------
`include "rs485_half_duplex_fifo_controller_defines.svh"

module rs485_half_duplex_fifo_controller import rs485hd_pkg::*; #(
  parameter int RECEIVE_DEPTH = RX_DEPTH_DEFAULT,
  parameter int SEND_DEPTH    = TX_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  rs485hd_in_if.sink    in_ch,
  rs485hd_out_if.source out_ch
);

  logic         q_valid;
  q_entry_t     q_head;
  logic         q_pop;
  back_status_t bk_st;

  // Command intake and queue.
  rs485hd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // FIFO and direction control.
  rs485hd_back #(
    .RECEIVE_DEPTH (RECEIVE_DEPTH),
    .SEND_DEPTH    (SEND_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .status  (bk_st)
  );

  // In receive direction the send FIFO must be empty.
  `RS485HD_ASSERT_NOW(a_rx_dir_send_empty, !bk_st.transmitting, bk_st.send_empty, "send FIFO not empty in receive direction")

  // While a RAM read is pending the output register is free for its result.
  `RS485HD_ASSERT_NOW(a_read_slot_free, bk_st.read_wait, !out_ch.valid, "output busy during FIFO read")

  // An accepted word is held in the queue in the next cycle.
  `RS485HD_ASSERT_NEXT(a_accept_queued, in_ch.valid && in_ch.ready, q_valid, "accepted word missing from queue")

  // A byte is only launched with the driver on.
  `RS485HD_ASSERT_NOW(a_launch_driver_on, out_ch.valid && out_ch.launch_valid, out_ch.driver_on, "launch without driver on")

endmodule

// ===== hdl/rs485hd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rs485hd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rs485hd_front.sv =====
// ----------------------------------------------------------------------------
// RS-485 controller front part
// Accepts command words, classifies them into operations and holds them in a
// short queue until the back part takes them.
// ----------------------------------------------------------------------------
module rs485hd_front import rs485hd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rs485hd_in_if.sink    in_ch,
  output logic          q_valid,
  output q_entry_t      q_head,
  input  logic          q_pop
);

  q_entry_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  logic                pop;
  q_entry_t            new_entry;

  // Classify the incoming command.
  always_comb begin
    new_entry.data = in_ch.data_byte;
    case (in_ch.command)
      CMD_QUEUE:  new_entry.op = OP_QUEUE;
      CMD_TAKE:   new_entry.op = OP_TAKE;
      CMD_ARRIVE: new_entry.op = OP_ARRIVE;
      CMD_DONE:   new_entry.op = OP_DONE;
      default:    new_entry.op = OP_DONE;
    endcase
  end

  // Queue handshake on both sides.
  assign in_ch.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_head      = entry_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

// ===== hdl/rs485hd_back.sv =====
// ----------------------------------------------------------------------------
// RS-485 controller back part
// Executes queued operations on the send and receive FIFOs, tracks the line
// direction and registers one result word per operation.
// ----------------------------------------------------------------------------
module rs485hd_back import rs485hd_pkg::*; #(
  parameter int RECEIVE_DEPTH = RX_DEPTH_DEFAULT,
  parameter int SEND_DEPTH    = TX_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  q_entry_t      q_head,
  output logic          q_pop,
  rs485hd_out_if.source out_ch,
  output back_status_t  status
);

  localparam int RX_AW = $clog2(RECEIVE_DEPTH);
  localparam int RX_CW = $clog2(RECEIVE_DEPTH + 1);
  localparam int TX_AW = $clog2(SEND_DEPTH);
  localparam int TX_CW = $clog2(SEND_DEPTH + 1);

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t             st_r, st_nxt;
  logic [RX_AW-1:0]   rx_head_r, rx_head_nxt;
  logic [RX_AW-1:0]   rx_tail_r, rx_tail_nxt;
  logic [RX_CW-1:0]   rx_cnt_r, rx_cnt_nxt;
  logic [TX_AW-1:0]   tx_head_r, tx_head_nxt;
  logic [TX_AW-1:0]   tx_tail_r, tx_tail_nxt;
  logic [TX_CW-1:0]   tx_cnt_r, tx_cnt_nxt;
  logic               tx_on_r, tx_on_nxt;
  logic               pend_rx_r, pend_rx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic [BYTE_W-1:0]  rd_r, rd_nxt;
  logic               lv_r, lv_nxt;
  logic [BYTE_W-1:0]  lb_r, lb_nxt;
  logic               drv_r, drv_nxt;
  logic               slot_free;
  logic               take;
  logic               rx_we;
  logic               tx_we;
  logic [BYTE_W-1:0]  rx_rdata;
  logic [BYTE_W-1:0]  tx_rdata;

  // Receive and send FIFO storage, read at the current head.
  rs485hd_ram #(.WIDTH(BYTE_W), .DEPTH(RECEIVE_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail_r),
    .wdata (q_head.data),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  rs485hd_ram #(.WIDTH(BYTE_W), .DEPTH(SEND_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail_r),
    .wdata (q_head.data),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  // An operation may start when the output register is free or being emptied.
  assign slot_free = !out_valid_r || out_ch.ready;
  assign take      = (st_r == S_EXEC) && q_valid && slot_free;
  assign q_pop     = take;

  // Operation execution.
  always_comb begin
    st_nxt        = st_r;
    rx_head_nxt   = rx_head_r;
    rx_tail_nxt   = rx_tail_r;
    rx_cnt_nxt    = rx_cnt_r;
    tx_head_nxt   = tx_head_r;
    tx_tail_nxt   = tx_tail_r;
    tx_cnt_nxt    = tx_cnt_r;
    tx_on_nxt     = tx_on_r;
    pend_rx_nxt   = pend_rx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ok_nxt        = ok_r;
    rd_nxt        = rd_r;
    lv_nxt        = lv_r;
    lb_nxt        = lb_r;
    drv_nxt       = drv_r;
    rx_we         = 1'b0;
    tx_we         = 1'b0;

    case (st_r)
      S_EXEC: begin
        if (take) begin
          // Default result; operations that pop wait for the RAM read.
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b0;
          rd_nxt        = '0;
          lv_nxt        = 1'b0;
          lb_nxt        = '0;
          drv_nxt       = tx_on_r;
          case (q_head.op)
            OP_QUEUE: begin
              if (!tx_on_r) begin
                // Send queue is empty here: the byte goes straight to the shifter.
                tx_on_nxt = 1'b1;
                ok_nxt    = 1'b1;
                lv_nxt    = 1'b1;
                lb_nxt    = q_head.data;
                drv_nxt   = 1'b1;
              end else if (tx_cnt_r != TX_CW'(SEND_DEPTH)) begin
                tx_we       = 1'b1;
                tx_tail_nxt = (tx_tail_r == TX_AW'(SEND_DEPTH - 1)) ? '0 :
                              tx_tail_r + 1'b1;
                tx_cnt_nxt  = tx_cnt_r + 1'b1;
                ok_nxt      = 1'b1;
              end
            end
            OP_TAKE: begin
              if (rx_cnt_r != '0) begin
                rx_head_nxt   = (rx_head_r == RX_AW'(RECEIVE_DEPTH - 1)) ? '0 :
                                rx_head_r + 1'b1;
                rx_cnt_nxt    = rx_cnt_r - 1'b1;
                pend_rx_nxt   = 1'b1;
                out_valid_nxt = 1'b0;
                st_nxt        = S_READ;
              end
            end
            OP_ARRIVE: begin
              if (rx_cnt_r != RX_CW'(RECEIVE_DEPTH)) begin
                rx_we       = 1'b1;
                rx_tail_nxt = (rx_tail_r == RX_AW'(RECEIVE_DEPTH - 1)) ? '0 :
                              rx_tail_r + 1'b1;
                rx_cnt_nxt  = rx_cnt_r + 1'b1;
                ok_nxt      = 1'b1;
              end
            end
            OP_DONE: begin
              if (tx_on_r) begin
                if (tx_cnt_r != '0) begin
                  tx_head_nxt   = (tx_head_r == TX_AW'(SEND_DEPTH - 1)) ? '0 :
                                  tx_head_r + 1'b1;
                  tx_cnt_nxt    = tx_cnt_r - 1'b1;
                  pend_rx_nxt   = 1'b0;
                  out_valid_nxt = 1'b0;
                  st_nxt        = S_READ;
                end else begin
                  // Queue drained: release the line and listen again.
                  tx_on_nxt = 1'b0;
                  drv_nxt   = 1'b0;
                end
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        // RAM data for the popped head is valid now.
        out_valid_nxt = 1'b1;
        ok_nxt        = 1'b1;
        drv_nxt       = tx_on_r;
        if (pend_rx_r) begin
          rd_nxt = rx_rdata;
          lv_nxt = 1'b0;
          lb_nxt = '0;
        end else begin
          rd_nxt = '0;
          lv_nxt = 1'b1;
          lb_nxt = tx_rdata;
        end
        st_nxt = S_EXEC;
      end
      default: begin
        st_nxt = S_EXEC;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_EXEC;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_cnt_r    <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_cnt_r    <= '0;
      tx_on_r     <= 1'b0;
      pend_rx_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      tx_on_r     <= tx_on_nxt;
      pend_rx_r   <= pend_rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    ok_r  <= ok_nxt;
    rd_r  <= rd_nxt;
    lv_r  <= lv_nxt;
    lb_r  <= lb_nxt;
    drv_r <= drv_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = ok_r;
  assign out_ch.read_byte    = rd_r;
  assign out_ch.launch_valid = lv_r;
  assign out_ch.launch_byte  = lb_r;
  assign out_ch.driver_on    = drv_r;

  assign status.read_wait    = (st_r == S_READ);
  assign status.transmitting = tx_on_r;
  assign status.send_empty   = (tx_cnt_r == '0);

endmodule
